>>> hw/rtl/mcid_pkg.sv
// ----------------------------------------------------------------------------
// mcid_pkg
// Types and constants shared by the multi-channel input debouncer.
// ----------------------------------------------------------------------------
package mcid_pkg;

  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned DEB_W      = 16;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DEB_W-1:0]  DEB_TIME_RST    = DEB_W'(50);
  localparam logic [MASK_W-1:0] ACTIVE_MASK_RST = '0;
  localparam logic [MASK_W-1:0] BOOT_MASK_RST   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TIME = 2'd0,
    CFG_ACTIVE_MASK   = 2'd1,
    CFG_BOOT_MASK     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_WAIT_EDGE     = 2'd0,
    PH_WAIT_DEBOUNCE = 2'd1,
    PH_WAIT_RELEASE  = 2'd2
  } phase_e;

  // One entry of the per-channel state memory.
  typedef struct packed {
    phase_e               phase;
    logic                 boot_guard;
    logic [TIME_BITS-1:0] start_time;
    logic                 debounced;
    logic                 edge_flag;
  } chan_state_t;

  localparam chan_state_t CHAN_STATE_RST = '{
    phase:      PH_WAIT_EDGE,
    boot_guard: 1'b1,
    start_time: '0,
    debounced:  1'b0,
    edge_flag:  1'b0
  };

endpackage

>>> hw/rtl/mcid_if.sv
// ----------------------------------------------------------------------------
// mcid_if
// Valid/ready channels for pin samples in and debounce results out.
// ----------------------------------------------------------------------------
interface mcid_in_if import mcid_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CH_W-1:0]      channel;
  logic                 level;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, output channel, output level, output now_ms, input ready);
  modport sink   (input valid, input channel, input level, input now_ms, output ready);
endinterface

interface mcid_out_if import mcid_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_channel;
  logic            raw_level;
  logic            debounced_level;
  logic            edge_event;
  logic            edge_seen;

  modport source (output valid, output out_channel, output raw_level,
                  output debounced_level, output edge_event, output edge_seen,
                  input ready);
  modport sink   (input valid, input out_channel, input raw_level,
                  input debounced_level, input edge_event, input edge_seen,
                  output ready);
endinterface

>>> hw/rtl/multi_channel_input_debouncer_top.sv
// A sample moves through the stage-1 register, then the output register once that is free.
// Throughput: one sample per cycle unless the output stalls; the state memory is read at the
// transfer and written back as the sample leaves stage 1, with forwarding when consecutive
// samples hit the same channel.
// Reset clears the pipeline, the registers and one valid flop per channel; an entry that is not
// valid reads as the reset state, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_channel_input_debouncer_top
// Per-channel debounce machines whose state lives in a small synchronous memory.
// ----------------------------------------------------------------------------
module multi_channel_input_debouncer_top import mcid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mcid_in_if.sink               in_i,
  mcid_out_if.source            out_o
);

  // Configuration registers
  logic [DEB_W-1:0]  deb_time_q;
  logic [MASK_W-1:0] active_mask_q;
  logic [MASK_W-1:0] boot_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_time_q    <= DEB_TIME_RST;
      active_mask_q <= ACTIVE_MASK_RST;
      boot_mask_q   <= BOOT_MASK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE_TIME: deb_time_q    <= cfg_wdata_i[DEB_W-1:0];
        CFG_ACTIVE_MASK:   active_mask_q <= cfg_wdata_i[MASK_W-1:0];
        CFG_BOOT_MASK:     boot_mask_q   <= cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid_q, out_valid_q;
  logic s1_adv, in_xfer, out_free;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_i.ready;

  // Stage 1 payload
  logic [CH_W-1:0]      s1_ch_q;
  logic                 s1_lvl_q;
  logic [TIME_BITS-1:0] s1_now_q;

  // State memory, valid flags and forwarding
  chan_state_t          mem [CHANNELS];
  logic [CHANNELS-1:0]  vld_q;
  chan_state_t          rd_q;
  logic                 rd_vld_q;
  logic                 fwd_q;
  chan_state_t          fwd_word_q;
  chan_state_t          cur, nxt;
  logic                 ch_ok;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      rd_q <= mem[in_i.channel];
    end
    if (s1_adv && ch_ok) begin
      mem[s1_ch_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      s1_valid_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (s1_adv && ch_ok) begin
        vld_q[s1_ch_q] <= 1'b1;
      end
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        rd_vld_q   <= vld_q[in_i.channel];
        // The entry being written at this edge is not yet in the memory read.
        fwd_q      <= s1_adv && ch_ok && (s1_ch_q == in_i.channel);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ch_q    <= in_i.channel;
      s1_lvl_q   <= in_i.level;
      s1_now_q   <= in_i.now_ms;
      fwd_word_q <= nxt;
    end
  end

  // Step logic
  logic                 act_lvl, boot_en, is_active, expired, event_b;
  logic [TIME_BITS-1:0] elapsed;

  assign ch_ok     = {1'b0, s1_ch_q} < (CH_W + 1)'(CHANNELS);
  assign act_lvl   = active_mask_q[s1_ch_q];
  assign boot_en   = boot_mask_q[s1_ch_q];
  assign is_active = (s1_lvl_q == act_lvl);
  assign elapsed   = s1_now_q - cur.start_time;
  assign expired   = elapsed >= TIME_BITS'(deb_time_q);

  always_comb begin
    if (fwd_q) begin
      cur = fwd_word_q;
    end else if (rd_vld_q) begin
      cur = rd_q;
    end else begin
      cur = CHAN_STATE_RST;
    end
  end

  always_comb begin
    nxt     = cur;
    event_b = 1'b0;
    unique case (cur.phase)
      PH_WAIT_DEBOUNCE: begin
        if (expired) begin
          if (is_active) begin
            nxt.debounced = act_lvl;
            nxt.edge_flag = 1'b1;
            nxt.phase     = PH_WAIT_RELEASE;
            event_b       = 1'b1;
          end else begin
            nxt.phase = PH_WAIT_EDGE;
          end
        end
      end
      PH_WAIT_RELEASE: begin
        if (!is_active) begin
          nxt.debounced = s1_lvl_q;
          nxt.phase     = PH_WAIT_EDGE;
        end
      end
      default: begin
        if (cur.boot_guard && boot_en) begin
          if (!is_active) begin
            nxt.boot_guard = 1'b0;
          end
        end else if (is_active) begin
          nxt.start_time = s1_now_q;
          nxt.phase      = PH_WAIT_DEBOUNCE;
        end
      end
    endcase
  end

  // Output register
  logic [CH_W-1:0] out_ch_q;
  logic            out_raw_q, out_deb_q, out_evt_q, out_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ch_q   <= s1_ch_q;
      out_raw_q  <= s1_lvl_q;
      out_deb_q  <= ch_ok && nxt.debounced;
      out_evt_q  <= ch_ok && event_b;
      out_seen_q <= ch_ok && nxt.edge_flag;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_channel     = out_ch_q;
  assign out_o.raw_level       = out_raw_q;
  assign out_o.debounced_level = out_deb_q;
  assign out_o.edge_event      = out_evt_q;
  assign out_o.edge_seen       = out_seen_q;

`ifndef SYNTHESIS
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advancing sample did not reach the output register");

  a_event_sets_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_evt_q) |-> out_seen_q)
    else $error("edge event without sticky edge flag");

  a_writeback_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && ch_ok) |=> vld_q[$past(s1_ch_q)])
    else $error("written channel entry not marked valid");
`endif

endmodule

>>> tb/tb_multi_channel_input_debouncer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_input_debouncer_top
// Drives pin samples through the debouncer and checks every result against a
// per-channel debounce predictor. Directed cases cover the boot guard, timer
// expiry at both ends of the interval range, time wrap and release. Random
// traffic then runs bouncy pins under several register settings, with random
// gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_multi_channel_input_debouncer_top;
  import mcid_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic            raw;
    logic            deb;
    logic            evt;
    logic            seen;
  } deb_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mcid_in_if  in_if ();
  mcid_out_if out_if ();

  multi_channel_input_debouncer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor copy of the registers and the per-channel state.
  logic [DEB_W-1:0]     mdl_deb_time;
  logic [MASK_W-1:0]    mdl_active_mask;
  logic [MASK_W-1:0]    mdl_boot_mask;
  phase_e               mdl_phase [CHANNELS];
  logic                 mdl_guard [CHANNELS];
  logic [TIME_BITS-1:0] mdl_start [CHANNELS];
  logic                 mdl_debounced [CHANNELS];
  logic                 mdl_edge_flag [CHANNELS];

  deb_result_t results_pending[$];

  int unsigned mismatches;
  int unsigned samples_sent;
  int unsigned results_checked;
  int unsigned edges_predicted;
  bit          no_idle;

  // Random traffic state: a running millisecond time and the level each pin
  // is settling toward.
  logic [TIME_BITS-1:0] sim_ms;
  logic                 pin_target [CHANNELS];

  always #5 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("Timeout: results still outstanding: %0d", results_pending.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void reset_debounce_model();
    mdl_deb_time    = DEB_TIME_RST;
    mdl_active_mask = ACTIVE_MASK_RST;
    mdl_boot_mask   = BOOT_MASK_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      mdl_phase[i]     = PH_WAIT_EDGE;
      mdl_guard[i]     = 1'b1;
      mdl_start[i]     = '0;
      mdl_debounced[i] = 1'b0;
      mdl_edge_flag[i] = 1'b0;
    end
  endfunction

  function automatic deb_result_t predict_debounce(input logic [CH_W-1:0] ch, input logic lvl,
                                                   input logic [TIME_BITS-1:0] now);
    deb_result_t          res;
    logic                 act;
    logic                 is_act;
    logic [TIME_BITS-1:0] elapsed;
    act         = mdl_active_mask[ch];
    is_act      = (lvl == act);
    res.channel = ch;
    res.raw     = lvl;
    res.evt     = 1'b0;
    case (mdl_phase[ch])
      PH_WAIT_DEBOUNCE: begin
        elapsed = now - mdl_start[ch];
        if (elapsed >= TIME_BITS'(mdl_deb_time)) begin
          if (is_act) begin
            mdl_debounced[ch] = act;
            mdl_edge_flag[ch] = 1'b1;
            res.evt           = 1'b1;
            mdl_phase[ch]     = PH_WAIT_RELEASE;
          end else begin
            mdl_phase[ch] = PH_WAIT_EDGE;
          end
        end
      end
      PH_WAIT_RELEASE: begin
        if (!is_act) begin
          mdl_debounced[ch] = lvl;
          mdl_phase[ch]     = PH_WAIT_EDGE;
        end
      end
      default: begin
        // While the boot guard applies, only an inactive level matters: it
        // lifts the guard and nothing else happens.
        if (mdl_guard[ch] && mdl_boot_mask[ch]) begin
          if (!is_act) mdl_guard[ch] = 1'b0;
        end else if (is_act) begin
          mdl_start[ch] = now;
          mdl_phase[ch] = PH_WAIT_DEBOUNCE;
        end
      end
    endcase
    res.deb  = mdl_debounced[ch];
    res.seen = mdl_edge_flag[ch];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Result side: random stalls and the comparison of each transfer.
  always @(posedge clk_i) out_if.ready <= no_idle || ($urandom_range(99) >= 13);

  always @(posedge clk_i) begin
    deb_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (results_pending.size() == 0) begin
        report_mismatch("result with nothing outstanding, channel", 32'(out_if.out_channel),
                        32'hffffffff);
      end else begin
        want = results_pending.pop_front();
        results_checked++;
        if (out_if.out_channel !== want.channel)
          report_mismatch("out_channel", 32'(out_if.out_channel), 32'(want.channel));
        if (out_if.raw_level !== want.raw)
          report_mismatch("raw_level", 32'(out_if.raw_level), 32'(want.raw));
        if (out_if.debounced_level !== want.deb)
          report_mismatch("debounced_level", 32'(out_if.debounced_level), 32'(want.deb));
        if (out_if.edge_event !== want.evt)
          report_mismatch("edge_event", 32'(out_if.edge_event), 32'(want.evt));
        if (out_if.edge_seen !== want.seen)
          report_mismatch("edge_seen", 32'(out_if.edge_seen), 32'(want.seen));
      end
    end
  end

  // Sample side. Entered and left just after a rising edge; valid stays high
  // across back-to-back transfers.
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic lvl,
                             input logic [TIME_BITS-1:0] now);
    deb_result_t res;
    while (!no_idle && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.level   <= lvl;
    in_if.now_ms  <= now;
    do @(posedge clk_i); while (!in_if.ready);
    res = predict_debounce(ch, lvl, now);
    if (res.evt) edges_predicted++;
    results_pending.push_back(res);
    samples_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges while the block is idle.
  task automatic write_config(input logic [DEB_W-1:0] deb, input logic [MASK_W-1:0] act,
                              input logic [MASK_W-1:0] boot);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DEBOUNCE_TIME;
    cfg_wdata_i <= CFG_DATA_W'(deb);
    @(posedge clk_i);
    mdl_deb_time = deb;
    cfg_idx_i   <= CFG_ACTIVE_MASK;
    cfg_wdata_i <= CFG_DATA_W'(act);
    @(posedge clk_i);
    mdl_active_mask = act;
    cfg_idx_i   <= CFG_BOOT_MASK;
    cfg_wdata_i <= CFG_DATA_W'(boot);
    @(posedge clk_i);
    mdl_boot_mask = boot;
    cfg_we_i <= 1'b0;
  endtask

  // Reset settings: active level 0 everywhere and the boot guard on.
  task automatic test_boot_guard_and_edge();
    send_sample(3'd0, 1'b0, 32'd1000);  // active at power-up, held off
    send_sample(3'd0, 1'b1, 32'd1001);  // inactive lifts the guard
    send_sample(3'd0, 1'b0, 32'd1002);  // timer starts
    send_sample(3'd0, 1'b0, 32'd1051);  // one short of the interval
    send_sample(3'd0, 1'b0, 32'd1052);  // interval reached, edge confirmed
    send_sample(3'd0, 1'b0, 32'd1060);
    send_sample(3'd0, 1'b1, 32'd1061);  // release
  endtask

  task automatic test_zero_interval_and_wrap();
    write_config(16'd0, 8'hff, 8'h00);
    send_sample(3'd7, 1'b1, 32'hffffffff);
    send_sample(3'd7, 1'b1, 32'h00000000);  // time wrapped, still expired
    send_sample(3'd7, 1'b0, 32'h00000000);
    send_sample(3'd3, 1'b1, 32'd5);
    send_sample(3'd3, 1'b0, 32'd5);         // level lost once the timer ran out
  endtask

  task automatic test_long_interval_and_masks();
    write_config(16'hffff, 8'h0f, 8'hf0);
    send_sample(3'd4, 1'b0, 32'd77);         // guard enabled again by the mask
    send_sample(3'd4, 1'b1, 32'd78);
    send_sample(3'd2, 1'b1, 32'hffffff00);
    send_sample(3'd2, 1'b1, 32'h0000fefe);   // one short of the longest interval
    send_sample(3'd2, 1'b0, 32'h0000feff);
    send_sample(3'd2, 1'b1, 32'h80000000);
    send_sample(3'd2, 1'b1, 32'h8000ffff);
    send_sample(3'd5, 1'b1, 32'h12345678);
    send_sample(3'd6, 1'b0, 32'h55555555);
    send_sample(3'd1, 1'b1, 32'haaaaaaaa);
  endtask

  // Bouncy pins on a running time base, with some samples at unrelated times.
  task automatic test_random_traffic(input int n_items, input logic [DEB_W-1:0] deb,
                                     input logic [MASK_W-1:0] act,
                                     input logic [MASK_W-1:0] boot, input bit calm);
    logic [CH_W-1:0]      ch;
    logic                 lvl;
    logic [CH_W-1:0]      focus;
    int unsigned          r;
    write_config(deb, act, boot);
    no_idle = calm;
    focus   = CH_W'($urandom_range(CHANNELS - 1));
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) focus = CH_W'($urandom_range(CHANNELS - 1));
      r = $urandom_range(99);
      if (r < 8) begin
        send_sample(CH_W'($urandom_range(CHANNELS - 1)), 1'($urandom), $urandom);
      end else begin
        ch = (r < 50) ? focus : CH_W'($urandom_range(CHANNELS - 1));
        if ($urandom_range(99) < 8) pin_target[ch] = ~pin_target[ch];
        lvl = pin_target[ch] ^ ($urandom_range(99) < 12);
        if ($urandom_range(99) < 2) sim_ms = sim_ms + $urandom;
        else sim_ms = sim_ms + $urandom_range(0, int'(deb) / 3 + 2);
        send_sample(ch, lvl, sim_ms);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_DEBOUNCE_TIME;
    cfg_wdata_i = '0;
    in_if.valid   = 1'b0;
    in_if.channel = '0;
    in_if.level   = 1'b0;
    in_if.now_ms  = '0;
    out_if.ready  = 1'b0;
    no_idle       = 1'b0;
    mismatches    = 0;
    samples_sent  = 0;
    results_checked = 0;
    edges_predicted = 0;
    sim_ms = $urandom;
    for (int i = 0; i < CHANNELS; i++) pin_target[i] = 1'($urandom);
    reset_debounce_model();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_boot_guard_and_edge();
    test_zero_interval_and_wrap();
    test_long_interval_and_masks();

    test_random_traffic(220, 16'd50, 8'h00, 8'hff, 1'b0);
    test_random_traffic(220, 16'd0, 8'hff, 8'h00, 1'b1);
    test_random_traffic(200, 16'hffff, 8'ha5, 8'h5a, 1'b0);
    test_random_traffic(220, 16'd1, 8'($urandom), 8'($urandom), 1'b0);
    test_random_traffic(220, 16'd7, 8'h3c, 8'hc3, 1'b0);
    test_random_traffic(220, 16'($urandom_range(2, 200)), 8'($urandom), 8'($urandom), 1'b0);

    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d samples and %0d results, %0d confirmed edges, over 8 settings.",
             samples_sent, results_checked, edges_predicted);
    if (results_pending.size() != 0)
      $display("%0d results never arrived", results_pending.size());
    if (mismatches == 0 && results_pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
